FILE: hw/rtl/iee_pkg.sv
package iee_pkg;

	// ASCII codes the evaluator reacts to
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam int VALUE_W = 32;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_SPACE,
		CLS_MUL,
		CLS_DIV,
		CLS_ADD,
		CLS_SUB,
		CLS_END
	} char_class_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_MUL,
		KIND_DIV
	} mul_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FACTOR,
		ST_UNIT,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic digit_en;
		logic latch_op;
		logic take_number;
		logic zero_div;
		logic unit_start;
		logic take_unit;
		logic set_mul;
		logic set_div;
		logic add_term;
		logic emit;
	} cmd_t;

	typedef struct packed {
		char_class_t in_class;
		char_class_t op_class;
		mul_kind_t   kind;
		logic        number_zero;
		logic        unit_done;
	} status_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cls;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			cls = CLS_DIGIT;
		end else begin
			unique case (c)
				CHAR_SPACE: cls = CLS_SPACE;
				CHAR_STAR:  cls = CLS_MUL;
				CHAR_SLASH: cls = CLS_DIV;
				CHAR_PLUS:  cls = CLS_ADD;
				CHAR_MINUS: cls = CLS_SUB;
				default:    cls = CLS_END;
			endcase
		end
		return cls;
	endfunction

endpackage

FILE: hw/rtl/infix_expression_evaluator.sv
// Infix expression evaluator. Feed one ASCII character per input item; digits build unsigned
// decimal numbers, spaces are skipped, + - * / are operators with * and / binding tighter and
// both levels running left to right. Any other character (normally '=') ends the expression and
// produces one result item: the low 32 bits of the value on m_tdata and a division-by-zero flag
// on m_tuser, after which the evaluator starts afresh. Arithmetic wraps modulo 2^DATA_WIDTH in
// two's complement; division truncates toward zero and a division by zero yields 0 and sets the
// flag. A missing number counts as 0. A digit or a space is absorbed in the idle state; any
// other character passes through factor completion and operator apply, and no new character is
// accepted until it is done; when it closes a * factor or a / factor with a nonzero divisor, the
// product or quotient comes from a shared shift-add / restoring divide unit that resolves one bit
// per cycle. An end character also waits while a previous result item is still unclaimed on the output register.
module infix_expression_evaluator import iee_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] char_code
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,  // [31:0] value
	output logic [0:0]         m_tuser   // [0] div_by_zero
);

	cmd_t    cmd;
	status_t status;

	// sequencing: character decode, factor completion, operator apply
	iee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// accumulators, pending operators and the result register
	iee_datapath #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_value (m_tdata),
		.out_dz    (m_tuser[0])
	);

endmodule

FILE: hw/rtl/iee_muldiv.sv
module iee_muldiv import iee_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  is_div,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int CNT_W = $clog2(DATA_WIDTH);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  div_mode_q;
	logic                  neg_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] opb_q;

	logic [DATA_WIDTH-1:0] a_mag;
	logic [DATA_WIDTH-1:0] b_mag;
	logic [DATA_WIDTH:0]   rem_sh;
	logic [DATA_WIDTH:0]   rem_sub;
	logic                  rem_ge;

	assign a_mag   = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
	assign b_mag   = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
	assign rem_sh  = {acc_q, quo_q[DATA_WIDTH-1]};
	assign rem_ge  = rem_sh >= {1'b0, opb_q};
	assign rem_sub = rem_sh - {1'b0, opb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit or one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			div_mode_q <= is_div;
			neg_q      <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
			acc_q      <= '0;
			quo_q      <= is_div ? a_mag : b;
			opb_q      <= is_div ? b_mag : a;
		end else if (busy_q) begin
			if (div_mode_q) begin
				acc_q <= rem_ge ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], rem_ge};
			end else begin
				acc_q <= acc_q + (quo_q[0] ? opb_q : '0);
				opb_q <= {opb_q[DATA_WIDTH-2:0], 1'b0};
				quo_q <= {1'b0, quo_q[DATA_WIDTH-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = div_mode_q ? (neg_q ? (~quo_q + 1'b1) : quo_q) : acc_q;

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("unit finished without running");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("unit restarted while busy");

endmodule

FILE: hw/rtl/iee_datapath.sv
module iee_datapath import iee_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_in,
	input  cmd_t               cmd,
	output status_t            status,
	output logic [VALUE_W-1:0] out_value,
	output logic               out_dz
);

	logic [DATA_WIDTH-1:0] sum_q;
	logic [DATA_WIDTH-1:0] term_q;
	logic [DATA_WIDTH-1:0] number_q;
	logic                  minus_q;
	mul_kind_t             kind_q;
	logic                  zdiv_q;
	logic [7:0]            op_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic                  out_dz_q;

	logic [DATA_WIDTH-1:0] digit_val;
	logic [DATA_WIDTH-1:0] number_next;
	logic [DATA_WIDTH-1:0] sum_next;
	logic [DATA_WIDTH-1:0] unit_result;
	logic                  unit_done;
	char_class_t           op_class;

	assign op_class    = classify(op_q);
	assign digit_val   = DATA_WIDTH'(char_in - CHAR_ZERO);
	// times ten as eight plus two
	assign number_next = (number_q << 3) + (number_q << 1) + digit_val;
	assign sum_next    = minus_q ? (sum_q - term_q) : (sum_q + term_q);

	iee_muldiv #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.unit_start),
		.is_div (kind_q == KIND_DIV),
		.a      (term_q),
		.b      (number_q),
		.done   (unit_done),
		.result (unit_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			term_q   <= '0;
			number_q <= '0;
			minus_q  <= 1'b0;
			kind_q   <= KIND_NONE;
			zdiv_q   <= 1'b0;
		end else begin
			if (cmd.digit_en) begin
				number_q <= number_next;
			end
			if (cmd.take_number) begin
				term_q   <= number_q;
				number_q <= '0;
			end
			if (cmd.zero_div) begin
				term_q   <= '0;
				number_q <= '0;
				zdiv_q   <= 1'b1;
			end
			if (cmd.take_unit) begin
				term_q   <= unit_result;
				number_q <= '0;
			end
			if (cmd.set_mul) begin
				kind_q <= KIND_MUL;
			end
			if (cmd.set_div) begin
				kind_q <= KIND_DIV;
			end
			if (cmd.add_term) begin
				sum_q   <= sum_next;
				term_q  <= '0;
				kind_q  <= KIND_NONE;
				minus_q <= (op_class == CLS_SUB);
			end
			if (cmd.emit) begin
				sum_q    <= '0;
				term_q   <= '0;
				number_q <= '0;
				minus_q  <= 1'b0;
				kind_q   <= KIND_NONE;
				zdiv_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_op) begin
			op_q <= char_in;
		end
		if (cmd.emit) begin
			out_value_q <= VALUE_W'(sum_next);
			out_dz_q    <= zdiv_q;
		end
	end

	assign status.in_class    = classify(char_in);
	assign status.op_class    = op_class;
	assign status.kind        = kind_q;
	assign status.number_zero = (number_q == '0);
	assign status.unit_done   = unit_done;

	assign out_value = out_value_q;
	assign out_dz    = out_dz_q;

endmodule

FILE: hw/rtl/iee_ctrl.sv
module iee_ctrl import iee_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;
	logic   m_tvalid_q;
	logic   accept;
	logic   out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && status.in_class != CLS_DIGIT && status.in_class != CLS_SPACE) begin
					state_next = ST_FACTOR;
				end
			end
			ST_FACTOR: begin
				if (status.kind == KIND_NONE ||
				    (status.kind == KIND_DIV && status.number_zero)) begin
					state_next = ST_APPLY;
				end else begin
					state_next = ST_UNIT;
				end
			end
			ST_UNIT: begin
				if (status.unit_done) begin
					state_next = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (status.op_class != CLS_END || out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					case (status.in_class)
						CLS_DIGIT: cmd.digit_en = 1'b1;
						CLS_SPACE: ;
						default:   cmd.latch_op = 1'b1;
					endcase
				end
			end
			ST_FACTOR: begin
				if (status.kind == KIND_NONE) begin
					cmd.take_number = 1'b1;
				end else if (status.kind == KIND_DIV && status.number_zero) begin
					cmd.zero_div = 1'b1;
				end else begin
					cmd.unit_start = 1'b1;
				end
			end
			ST_UNIT: begin
				cmd.take_unit = status.unit_done;
			end
			ST_APPLY: begin
				case (status.op_class)
					CLS_MUL:                cmd.set_mul  = 1'b1;
					CLS_DIV:                cmd.set_div  = 1'b1;
					CLS_ADD, CLS_SUB:       cmd.add_term = 1'b1;
					default:                cmd.emit     = out_free;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

	a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten before it was taken");

	a_unit_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNIT && status.unit_done) |=> state_q == ST_APPLY)
		else $error("unit result not applied");

endmodule
